/* src/range_gated_slot_allocator_top_assert.svh */
// assertion macros for the range gated slot allocator
// no dependencies; taken in by the top level with an include
`ifndef RANGE_GATED_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define RANGE_GATED_SLOT_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define RGSA_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("rgsa assertion failed");
// next-cycle implication, checked outside reset
`define RGSA_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("rgsa assertion failed");
`else
`define RGSA_ASSERT_IMP(label, clk, rst, lhs, rhs)
`define RGSA_ASSERT_NXT(label, clk, rst, lhs, rhs)
`endif

`endif

/* src/rgsa_pkg.sv */
// shared types and constants for the range gated slot allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rgsa_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = 4;
   localparam int COUNT_W   = 5;
   localparam int COORD_W   = 16;
   localparam int SQ_W      = 2 * COORD_W;

   typedef enum logic {
      OP_CONNECT = 1'b0,
      OP_UPDATE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_CENTER_X    = 2'd0,
      CSR_CENTER_Y    = 2'd1,
      CSR_RADIUS      = 2'd2,
      CSR_STATION_ID  = 2'd3
   } csr_idx_type;

   typedef struct packed {
      op_type               operation;
      logic [COORD_W-1:0]   pos_x;
      logic [COORD_W-1:0]   pos_y;
      logic [SLOT_W-1:0]    unit_slot;
   } req_type;

   typedef struct packed {
      logic                 accepted;
      logic [SLOT_W-1:0]    granted_slot;
      logic [COORD_W-1:0]   station_id_out;
      logic [COUNT_W-1:0]   occupied_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic square;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* src/rgsa_if.sv */
// valid/ready channel interfaces for requests and responses
// depends on rgsa_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rgsa_req_if;
   logic             valid;
   logic             ready;
   rgsa_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rgsa_rsp_if;
   logic             valid;
   logic             ready;
   rgsa_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/rgsa_ctrl.sv */
// sequencing state machine: capture, square, decide
// depends on rgsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgsa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  rgsa_pkg::status_type      status,
   output rgsa_pkg::cmd_type         cmd
);
   import rgsa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid && ready_ff;
            if (req_valid && ready_ff) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            // hold here while the previous result is still unclaimed
            cmd.commit = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

/* src/rgsa_dp.sv */
// datapath: config registers, range test, slot table and result register
// depends on rgsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgsa_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  rgsa_pkg::cmd_type                cmd,
   output rgsa_pkg::status_type             status,
   input  wire logic                        csr_wr_en,
   input  rgsa_pkg::csr_idx_type            csr_index,
   input  wire logic [rgsa_pkg::COORD_W-1:0] csr_wr_data,
   input  rgsa_pkg::req_type                req_payload,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output rgsa_pkg::rsp_type                rsp_payload
);
   import rgsa_pkg::*;

   logic [COORD_W-1:0]   center_x_ff, center_y_ff, radius_ff, station_id_ff;
   req_type              item_ff;
   logic [SQ_W-1:0]      dx2_ff, dy2_ff, r2_ff;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [COORD_W-1:0]   dx, dy;
   logic [SQ_W:0]        dist2;
   logic                 in_range;
   logic                 free_found;
   logic [SLOT_W-1:0]    free_slot;
   logic                 table_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         radius_ff     <= '0;
         station_id_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CENTER_X:   center_x_ff   <= csr_wr_data;
            CSR_CENTER_Y:   center_y_ff   <= csr_wr_data;
            CSR_RADIUS:     radius_ff     <= csr_wr_data;
            CSR_STATION_ID: station_id_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // absolute differences, squared in the next register stage
   assign dx = (item_ff.pos_x >= center_x_ff) ? item_ff.pos_x - center_x_ff
                                              : center_x_ff - item_ff.pos_x;
   assign dy = (item_ff.pos_y >= center_y_ff) ? item_ff.pos_y - center_y_ff
                                              : center_y_ff - item_ff.pos_y;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
      if (cmd.square) begin
         dx2_ff <= SQ_W'(dx) * SQ_W'(dx);
         dy2_ff <= SQ_W'(dy) * SQ_W'(dy);
         r2_ff  <= SQ_W'(radius_ff) * SQ_W'(radius_ff);
      end
   end

   assign dist2    = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign in_range = (dist2 <= {1'b0, r2_ff});

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!valid_ff[i] && !free_found) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   assign table_full = (count_ff >= COUNT_W'(NUM_SLOTS));

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      rsp_in   = '0;
      unique case (item_ff.operation)
         OP_CONNECT: begin
            if (in_range && !table_full && free_found) begin
               valid_in[free_slot]   = 1'b1;
               count_in              = count_ff + COUNT_W'(1);
               rsp_in.accepted       = 1'b1;
               rsp_in.granted_slot   = free_slot;
               rsp_in.station_id_out = station_id_ff;
            end
         end
         OP_UPDATE: begin
            if (in_range) begin
               rsp_in.accepted = 1'b1;
            end else if (valid_ff[item_ff.unit_slot]) begin
               // out of range releases the slot
               valid_in[item_ff.unit_slot] = 1'b0;
               count_in                    = count_ff - COUNT_W'(1);
            end
         end
         default: ;
      endcase
      rsp_in.occupied_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            valid_ff     <= valid_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

endmodule

`default_nettype wire

/* src/range_gated_slot_allocator_top.sv */
// Range gated slot allocator. Each request on req_chan is a connect or a
// position update; each produces exactly one response on rsp_chan.
// A connect inside the coverage circle takes the lowest free slot and
// returns it with the station id; an update out of range frees its slot.
// Both channels move one transfer at an edge where valid and ready are high.
// Configuration is written through csr_wr_en / csr_index / csr_wr_data by
// the user only while no request is in flight; the block does not enforce it.
// After the request transfer the item passes a squaring stage, then decide
// and table update, which registers the response and raises its valid.
// Requests are taken one at a time; req_chan.ready is high only while
// the sequencer is idle, so the three-step pass of each item paces intake.
// A finished response sits in an output register, so a new request is taken
// while it waits; if rsp_chan stalls, the next item holds in its decide step
// until the register frees, and the slot table is not touched meanwhile.
// Reset (synchronous, active high) clears all slots, the occupied count,
// the config registers and the response valid flag; req_chan.ready rises
// in the cycle after reset drops.
// depends on rgsa_pkg, rgsa_if, rgsa_ctrl, rgsa_dp
`timescale 1ns / 1ps
`default_nettype none

`include "range_gated_slot_allocator_top_assert.svh"

module range_gated_slot_allocator_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   rgsa_req_if.sink                          req_chan,
   rgsa_rsp_if.source                        rsp_chan,
   input  wire logic                         csr_wr_en,
   input  rgsa_pkg::csr_idx_type             csr_index,
   input  wire logic [rgsa_pkg::COORD_W-1:0] csr_wr_data
);
   import rgsa_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;
   rsp_type    rsp_payload;

   rgsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rgsa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_chan.payload),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

   // one item in flight at a time
   `RGSA_ASSERT_NXT(a_one_in_flight, clock, reset, req_chan.valid && req_ready, !req_ready)
   // refused results carry no slot and no station id
   `RGSA_ASSERT_IMP(a_refused_clean, clock, reset, rsp_valid && !rsp_payload.accepted, rsp_payload.granted_slot == '0 && rsp_payload.station_id_out == '0)
   // occupancy never exceeds the table
   `RGSA_ASSERT_IMP(a_count_bound, clock, reset, rsp_valid, rsp_payload.occupied_count <= COUNT_W'(NUM_SLOTS))

endmodule

`default_nettype wire

/* dv/rgsa_slot_checker.sv */
`timescale 1ns / 1ps
// response checker for the range gated slot allocator: mirrors the slot table and the
// coverage registers, predicts one response per request transfer and compares in order
// depends on rgsa_pkg and rgsa_if
module rgsa_slot_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   rgsa_req_if                               req_mon,
   rgsa_rsp_if                               rsp_mon,
   input  wire logic                         csr_wr_en,
   input  rgsa_pkg::csr_idx_type             csr_index,
   input  wire logic [rgsa_pkg::COORD_W-1:0] csr_wr_data,
   input  wire logic                         end_of_test,
   output int                                pending,
   output int                                fail_count
);
   import rgsa_pkg::*;

   logic [COORD_W-1:0]   ctr_x;
   logic [COORD_W-1:0]   ctr_y;
   logic [COORD_W-1:0]   radius;
   logic [COORD_W-1:0]   station;
   logic [NUM_SLOTS-1:0] occupied;
   logic [COUNT_W-1:0]   n_occupied;
   rsp_type              predicted_rsps[$];
   bit                   leftover_flagged;

   task automatic note_failure(input string msg);
      $display("[%0t] rgsa check: %s", $time, msg);
      fail_count++;
   endtask

   // exact squared distance against squared radius, boundary counts as inside
   function automatic logic within_coverage(input logic [COORD_W-1:0] px,
                                            input logic [COORD_W-1:0] py);
      logic [63:0] dx;
      logic [63:0] dy;
      logic [63:0] r;
      dx = 64'((px >= ctr_x) ? px - ctr_x : ctr_x - px);
      dy = 64'((py >= ctr_y) ? py - ctr_y : ctr_y - py);
      r  = 64'(radius);
      return (dx * dx + dy * dy) <= (r * r);
   endfunction

   // positions are never visible at the outputs, so only occupancy is tracked
   function automatic rsp_type admit_unit(input req_type item);
      rsp_type r;
      logic    in_cov;
      logic    found;
      int      i;
      r      = '0;
      found  = 1'b0;
      in_cov = within_coverage(item.pos_x, item.pos_y);
      if (item.operation == OP_CONNECT) begin
         if (in_cov && n_occupied < NUM_SLOTS) begin
            for (i = 0; i < NUM_SLOTS && !found; i++) begin
               if (!occupied[i]) begin
                  found          = 1'b1;
                  occupied[i]    = 1'b1;
                  n_occupied     = n_occupied + COUNT_W'(1);
                  r.accepted     = 1'b1;
                  r.granted_slot = i[SLOT_W-1:0];
                  r.station_id_out = station;
               end
            end
         end
      end else if (int'(item.unit_slot) < NUM_SLOTS) begin
         if (in_cov) begin
            // a free slot refreshed in range stays free
            r.accepted = 1'b1;
         end else if (occupied[item.unit_slot]) begin
            occupied[item.unit_slot] = 1'b0;
            if (n_occupied > 0)
               n_occupied = n_occupied - COUNT_W'(1);
         end
      end
      r.occupied_count = n_occupied;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         ctr_x      = '0;
         ctr_y      = '0;
         radius     = '0;
         station    = '0;
         occupied   = '0;
         n_occupied = '0;
         predicted_rsps.delete();
         leftover_flagged = 1'b0;
      end else begin
         // a response transfer always belongs to an earlier request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (predicted_rsps.size() == 0) begin
               note_failure($sformatf("response %h with no request outstanding", got));
            end else begin
               want = predicted_rsps.pop_front();
               if (got.accepted !== want.accepted)
                  note_failure($sformatf("accepted %h, expected %h",
                                         got.accepted, want.accepted));
               if (got.granted_slot !== want.granted_slot)
                  note_failure($sformatf("granted_slot %h, expected %h",
                                         got.granted_slot, want.granted_slot));
               if (got.station_id_out !== want.station_id_out)
                  note_failure($sformatf("station_id_out %h, expected %h",
                                         got.station_id_out, want.station_id_out));
               if (got.occupied_count !== want.occupied_count)
                  note_failure($sformatf("occupied_count %h, expected %h",
                                         got.occupied_count, want.occupied_count));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CENTER_X:   ctr_x   = csr_wr_data;
               CSR_CENTER_Y:   ctr_y   = csr_wr_data;
               CSR_RADIUS:     radius  = csr_wr_data;
               CSR_STATION_ID: station = csr_wr_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            predicted_rsps.push_back(admit_unit(req_mon.payload));
         if (end_of_test && predicted_rsps.size() != 0 && !leftover_flagged) begin
            leftover_flagged = 1'b1;
            note_failure($sformatf("%0d responses never arrived", predicted_rsps.size()));
         end
      end
      pending <= predicted_rsps.size();
   end

endmodule

/* dv/tb_range_gated_slot_allocator_top.sv */
`timescale 1ns / 1ps
// testbench top for the range gated slot allocator: clock, reset, csr writes,
// request stimulus with random idling on both channels, watchdog and verdict
// depends on rgsa_pkg, rgsa_if, rgsa_slot_checker and range_gated_slot_allocator_top
module tb_range_gated_slot_allocator_top;
   import rgsa_pkg::*;

   localparam int SETTLE_CYCLES = 6;
   localparam int QUIET_LIMIT   = 4000;
   localparam int BLOCK_UNITS   = 50;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   csr_idx_type        csr_index;
   logic [COORD_W-1:0] csr_wr_data;
   logic               end_of_test;
   int                 send_idle_pct;
   int                 recv_idle_pct;
   int                 quiet_cycles;
   int                 pending_rsps;
   int                 check_failures;
   logic [COORD_W-1:0] cov_cx;
   logic [COORD_W-1:0] cov_cy;
   logic [COORD_W-1:0] cov_radius;

   rgsa_req_if req_chan ();
   rgsa_rsp_if rsp_chan ();

   range_gated_slot_allocator_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rgsa_slot_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .end_of_test (end_of_test),
      .pending     (pending_rsps),
      .fail_count  (check_failures)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // mostly near the center so that both sides of the boundary get hit
   function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] centre,
                                                     input int unsigned reach);
      int unsigned roll;
      int unsigned off;
      roll = $urandom_range(99);
      off  = $urandom_range(reach + reach / 4 + 1);
      if (roll < 70)
         return $urandom_range(1) ? centre + off[COORD_W-1:0] : centre - off[COORD_W-1:0];
      if (roll < 85)
         return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      return COORD_W'($urandom());
   endfunction

   task automatic program_coverage(input logic [COORD_W-1:0] cx,
                                   input logic [COORD_W-1:0] cy,
                                   input logic [COORD_W-1:0] radius,
                                   input logic [COORD_W-1:0] sid);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_CENTER_X;
      csr_wr_data <= cx;
      @(posedge clock);
      csr_index   <= CSR_CENTER_Y;
      csr_wr_data <= cy;
      @(posedge clock);
      csr_index   <= CSR_RADIUS;
      csr_wr_data <= radius;
      @(posedge clock);
      csr_index   <= CSR_STATION_ID;
      csr_wr_data <= sid;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cov_cx      = cx;
      cov_cy      = cy;
      cov_radius  = radius;
   endtask

   task automatic send_unit(input op_type op, input logic [COORD_W-1:0] px,
                            input logic [COORD_W-1:0] py, input logic [SLOT_W-1:0] slot);
      req_type item;
      item.operation = op;
      item.pos_x     = px;
      item.pos_y     = py;
      item.unit_slot = slot;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // the pending count is registered in the checker, so look only after the next edge
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsps != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int n;
      int phase;
      int blk;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_CENTER_X;
      csr_wr_data      = '0;
      end_of_test      = 1'b0;
      send_idle_pct    = 37;
      recv_idle_pct    = 69;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // small circle mid-field: centre, boundary hits, release and refill, full table
      program_coverage(16'h8000, 16'h8000, 16'd5, 16'hFFFF);
      send_unit(OP_CONNECT, 16'h8000, 16'h8000, 4'd0);
      send_unit(OP_CONNECT, 16'h8005, 16'h8000, 4'd7);
      send_unit(OP_CONNECT, 16'h7FFD, 16'h7FFC, 4'd0);
      send_unit(OP_CONNECT, 16'h8004, 16'h8004, 4'd0);
      send_unit(OP_UPDATE,  16'h8001, 16'h8001, 4'd1);
      send_unit(OP_UPDATE,  16'h8006, 16'h8000, 4'd1);
      send_unit(OP_UPDATE,  16'h8006, 16'h8000, 4'd1);
      send_unit(OP_UPDATE,  16'h8000, 16'h8000, 4'd9);
      send_unit(OP_CONNECT, 16'h7FFB, 16'h8000, 4'd0);
      for (n = 0; n < 13; n++)
         send_unit(OP_CONNECT, 16'h8000, 16'h8000 - 16'(n % 6), 4'(n));
      send_unit(OP_CONNECT, 16'h8000, 16'h8000, 4'd0);

      // corner centre with the widest radius
      drain_responses();
      program_coverage(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
      send_unit(OP_UPDATE,  16'hFFFF, 16'hFFFF, 4'd15);
      send_unit(OP_UPDATE,  16'hFFFF, 16'h0000, 4'd3);
      send_unit(OP_CONNECT, 16'h0000, 16'h0000, 4'd15);

      for (phase = 0; phase < 3; phase++) begin
         for (blk = 0; blk < 4; blk++) begin
            drain_responses();
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 37 : 0;
            case (blk)
               0: program_coverage(COORD_W'($urandom()), COORD_W'($urandom()),
                                   COORD_W'($urandom_range(1, 3000)), COORD_W'($urandom()));
               1: program_coverage($urandom_range(1) ? 16'hFFFF : 16'h0000,
                                   $urandom_range(1) ? 16'hFFFF : 16'h0000,
                                   16'hFFFF, COORD_W'($urandom()));
               2: program_coverage(COORD_W'($urandom()), COORD_W'($urandom()), 16'd0,
                                   COORD_W'($urandom()));
               default: program_coverage(COORD_W'($urandom()), COORD_W'($urandom()),
                                         COORD_W'($urandom()), COORD_W'($urandom()));
            endcase
            for (n = 0; n < BLOCK_UNITS; n++)
               send_unit($urandom_range(1) ? OP_UPDATE : OP_CONNECT,
                         pick_coord(cov_cx, cov_radius), pick_coord(cov_cy, cov_radius),
                         SLOT_W'($urandom_range(NUM_SLOTS - 1)));
         end
      end

      drain_responses();
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      if (check_failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* range_gated_slot_allocator_top.f */
+incdir+src
src/rgsa_pkg.sv
src/rgsa_if.sv
src/rgsa_ctrl.sv
src/rgsa_dp.sv
src/range_gated_slot_allocator_top.sv
dv/rgsa_slot_checker.sv
dv/tb_range_gated_slot_allocator_top.sv
